// File: hdl/lkv_pkg.sv
// shared types and constants for the lru key-value cache
`timescale 1ns / 1ps

package lkv_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int KEY_BITS_DEF   = 32;
   localparam int VALUE_BITS_DEF = 32;

   localparam int              CAP_BITS  = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_PUT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_step;
      logic decide;
      logic upd_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic cnt_done;
      logic need_update;
   } stat_type;

endpackage

// File: hdl/lru_key_value_cache_top.sv
// top level of the fully associative lru key-value cache
`timescale 1ns / 1ps

// Fully associative key-value cache of DEPTH entries with least-recently-used
// replacement. Each transaction is a get (req_func 0) or a put (req_func 1);
// the result reports a prior hit, the value read on a get hit, and the key
// evicted when a put of a new key finds the cache at capacity. Entries live in
// rams with one read and one write port and are examined one per cycle: a
// transaction is accepted in idle, scanned, decided, given a recency update
// pass (skipped on a get miss) and handed to the response register once that
// register is free. The capacity register (reset 16) is saturated to 1..DEPTH
// and may be written only while the cache is idle.

module lru_key_value_cache_top
   import lkv_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic [VALUE_BITS-1:0] rsp_read_value,
   output logic                  rsp_evicted,
   output logic [KEY_BITS-1:0]   rsp_evicted_key,
   input  logic                  csr_write_enable,
   input  logic [CAP_BITS-1:0]   csr_write_data
);

   cmd_type  cmd;
   stat_type stat;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lkv_dpath #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_key          (req_key),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_key  (rsp_evicted_key)
   );

`ifndef SYNTHESIS
   a_evict_not_hit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> !rsp_hit)
      else $error("eviction reported on a hit");

   a_evict_key_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted) |-> (rsp_evicted_key == '0))
      else $error("evicted key nonzero without eviction");

   a_miss_value_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_read_value == '0))
      else $error("read value nonzero on a miss");

   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (!reset && req_valid && req_ready) |=> (!req_ready && cmd.scan_step))
      else $error("accepted transaction did not start a scan");
`endif

endmodule

// File: hdl/lkv_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lkv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lkv_ctrl.sv
// sequencer for lookup scan, decision, age update and response
`timescale 1ns / 1ps

module lkv_ctrl
   import lkv_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.cnt_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = stat.need_update ? ST_UPDATE : ST_FINISH;
         end
         ST_UPDATE: begin
            if (stat.cnt_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
         end
         ST_UPDATE: begin
            cmd.upd_step = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hdl/lkv_dpath.sv
// key, value and age stores with scan, eviction and recency update logic
`timescale 1ns / 1ps

module lkv_dpath
   import lkv_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic                  req_func,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  csr_write_enable,
   input  logic [CAP_BITS-1:0]   csr_write_data,
   output logic                  rsp_hit,
   output logic [VALUE_BITS-1:0] rsp_read_value,
   output logic                  rsp_evicted,
   output logic [KEY_BITS-1:0]   rsp_evicted_key
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int OCC_W = $clog2(DEPTH + 1);

   logic [CAP_BITS-1:0] cap_ff;
   logic [OCC_W-1:0]    cap_eff;
   logic [OCC_W-1:0]    occ_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                valid_ff [DEPTH];

   logic                  func_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;

   logic                found_ff;
   logic [IDX_W-1:0]    match_idx_ff;
   logic [IDX_W-1:0]    match_age_ff;
   logic [IDX_W-1:0]    lru_idx_ff;
   logic [KEY_BITS-1:0] lru_key_ff;
   logic                free_found_ff;
   logic [IDX_W-1:0]    free_idx_ff;

   logic             evict_ff;
   logic [IDX_W-1:0] target_ff;
   logic [IDX_W-1:0] limit_ff;
   logic             inc_all_ff;

   logic                  hit_ff;
   logic [VALUE_BITS-1:0] read_value_ff;
   logic                  evicted_ff;
   logic [KEY_BITS-1:0]   evicted_key_ff;

   logic [IDX_W-1:0]      rd_addr;
   logic [IDX_W-1:0]      proc_idx;
   logic                  proc_on;
   logic                  proc_valid;
   logic [IDX_W-1:0]      occ_m1;
   logic [KEY_BITS-1:0]   key_rd;
   logic [IDX_W-1:0]      age_rd;
   logic [VALUE_BITS-1:0] val_rd;
   logic [IDX_W-1:0]      age_new;
   logic                  put_miss;
   logic                  evict_now;
   logic [IDX_W-1:0]      target_now;

   // effective capacity, saturated to 1..DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = OCC_W'(1);
      end else if (int'(cap_ff) > DEPTH) begin
         cap_eff = OCC_W'(DEPTH);
      end else begin
         cap_eff = OCC_W'(cap_ff);
      end
   end

   assign rd_addr    = (int'(cnt_ff) < DEPTH) ? cnt_ff[IDX_W-1:0] : '0;
   assign proc_idx   = IDX_W'(cnt_ff - CNT_W'(1));
   assign proc_on    = (cnt_ff != '0);
   assign proc_valid = proc_on && valid_ff[proc_idx];
   assign occ_m1     = IDX_W'(occ_ff - OCC_W'(1));

   assign put_miss   = (func_ff == FUNC_PUT) && !found_ff;
   assign evict_now  = put_miss && (occ_ff >= cap_eff);
   assign target_now = found_ff ? match_idx_ff : (evict_now ? lru_idx_ff : free_idx_ff);

   always_comb begin
      if (proc_idx == target_ff) begin
         age_new = '0;
      end else if (proc_valid && (inc_all_ff || age_rd < limit_ff)) begin
         age_new = age_rd + IDX_W'(1);
      end else begin
         age_new = age_rd;
      end
   end

   assign stat.cnt_done    = (cnt_ff == CNT_W'(DEPTH));
   assign stat.need_update = found_ff || (func_ff == FUNC_PUT);

   lkv_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.decide && put_miss),
      .wr_addr (target_now),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   lkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val_ram (
      .clock   (clock),
      .wr_en   (cmd.decide && (func_ff == FUNC_PUT)),
      .wr_addr (target_now),
      .wr_data (value_ff),
      .rd_addr (match_idx_ff),
      .rd_data (val_rd)
   );

   lkv_ram #(.WIDTH(IDX_W), .DEPTH(DEPTH)) u_age_ram (
      .clock   (clock),
      .wr_en   (cmd.upd_step && proc_on),
      .wr_addr (proc_idx),
      .wr_data (age_new),
      .rd_addr (rd_addr),
      .rd_data (age_rd)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
         occ_ff <= '0;
         cnt_ff <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         if (cmd.load || cmd.decide) begin
            cnt_ff <= '0;
         end else if (cmd.scan_step || cmd.upd_step) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.decide && put_miss) begin
            valid_ff[target_now] <= 1'b1;
            if (!evict_now) begin
               occ_ff <= occ_ff + OCC_W'(1);
            end
         end
      end
   end

   // transaction and scan registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff       <= req_func;
         key_ff        <= req_key;
         value_ff      <= req_value;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end
      if (cmd.scan_step && proc_on) begin
         if (proc_valid && key_rd == key_ff) begin
            found_ff     <= 1'b1;
            match_idx_ff <= proc_idx;
            match_age_ff <= age_rd;
         end
         if (proc_valid && age_rd == occ_m1) begin
            lru_idx_ff <= proc_idx;
            lru_key_ff <= key_rd;
         end
         if (!proc_valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= proc_idx;
         end
      end
      if (cmd.decide) begin
         evict_ff   <= evict_now;
         target_ff  <= target_now;
         limit_ff   <= match_age_ff;
         inc_all_ff <= !found_ff;
      end
      if (cmd.finish) begin
         hit_ff         <= found_ff;
         read_value_ff  <= (found_ff && func_ff == FUNC_GET) ? val_rd : '0;
         evicted_ff     <= evict_ff;
         evicted_key_ff <= evict_ff ? lru_key_ff : '0;
      end
   end

   assign rsp_hit         = hit_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evicted_key_ff;

endmodule

// File: bench/tb_top.sv
// self-checking testbench for the lru key-value cache
`timescale 1ns / 1ps

module tb_top;
   import lkv_pkg::*;

   localparam int KB          = KEY_BITS_DEF;
   localparam int VB          = VALUE_BITS_DEF;
   localparam int RAND_ITEMS  = 1550;
   localparam int RSP_HOLD    = 400;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 2 * DEPTH_DEF + 8;
   localparam int NUM_ROWS    = 24;

   typedef struct packed {
      logic          hit;
      logic [VB-1:0] read_value;
      logic          evicted;
      logic [KB-1:0] evicted_key;
   } cache_rsp_type;

   typedef enum logic [1:0] {ROW_TYPED, ROW_PRED, ROW_CAP} row_kind_type;

   // capacity rows carry the new capacity in value
   typedef struct packed {
      row_kind_type  kind;
      logic          func;
      logic [KB-1:0] key;
      logic [VB-1:0] value;
      cache_rsp_type want;
   } stim_row_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic                req_func         = FUNC_GET;
   logic [KB-1:0]       req_key          = '0;
   logic [VB-1:0]       req_value        = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic                rsp_hit;
   logic [VB-1:0]       rsp_read_value;
   logic                rsp_evicted;
   logic [KB-1:0]       rsp_evicted_key;
   logic                csr_write_enable = 1'b0;
   logic [CAP_BITS-1:0] csr_write_data   = '0;

   // shadow copy of the cache contents
   logic                ent_valid [DEPTH_DEF];
   logic [KB-1:0]       ent_key   [DEPTH_DEF];
   logic [VB-1:0]       ent_value [DEPTH_DEF];
   int                  ent_age   [DEPTH_DEF];
   int                  ent_count;
   logic [CAP_BITS-1:0] cap_reg;

   cache_rsp_type due_rsp_q [$];
   int unsigned fail_cnt    = 0;
   int unsigned idle_cycles = 0;
   bit          hold_rsp    = 1'b0;

   int phase_caps [8] = '{2, 16, 0, 31, 1, 17, 5, 8};

   stim_row_type dir_rows [0:NUM_ROWS-1] = '{
      '{ROW_TYPED, FUNC_GET, 32'h0000_0000, 32'h0000_0000, '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{ROW_TYPED, FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF, '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{ROW_TYPED, FUNC_GET, 32'h0000_0000, 32'h0000_0000, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
      '{ROW_TYPED, FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000, '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{ROW_TYPED, FUNC_GET, 32'hFFFF_FFFF, 32'hDEAD_BEEF, '{1'b1, 32'h0, 1'b0, 32'h0}},
      '{ROW_TYPED, FUNC_PUT, 32'h0000_0000, 32'h1234_5678, '{1'b1, 32'h0, 1'b0, 32'h0}},
      '{ROW_TYPED, FUNC_GET, 32'h0000_0000, 32'h0000_0000, '{1'b1, 32'h1234_5678, 1'b0, 32'h0}},
      '{ROW_TYPED, FUNC_GET, 32'h5555_5555, 32'h0000_0000, '{1'b0, 32'h0, 1'b0, 32'h0}},
      '{ROW_CAP,   FUNC_GET, 32'h0000_0000, 32'd1,         '0},
      '{ROW_TYPED, FUNC_PUT, 32'hAAAA_AAAA, 32'h0000_0001, '{1'b0, 32'h0, 1'b1, 32'hFFFF_FFFF}},
      '{ROW_PRED,  FUNC_GET, 32'h0000_0000, 32'h0000_0000, '0},
      '{ROW_PRED,  FUNC_PUT, 32'h5555_5555, 32'h0000_0002, '0},
      '{ROW_CAP,   FUNC_GET, 32'h0000_0000, 32'd0,         '0},
      '{ROW_PRED,  FUNC_PUT, 32'h0000_0001, 32'h0000_0003, '0},
      '{ROW_PRED,  FUNC_PUT, 32'h0000_0002, 32'h0000_0004, '0},
      '{ROW_PRED,  FUNC_GET, 32'h0000_0001, 32'h0000_0000, '0},
      '{ROW_CAP,   FUNC_GET, 32'h0000_0000, 32'd31,        '0},
      '{ROW_PRED,  FUNC_PUT, 32'h0000_0003, 32'h0000_0005, '0},
      '{ROW_PRED,  FUNC_PUT, 32'h0000_0004, 32'h0000_0006, '0},
      '{ROW_PRED,  FUNC_GET, 32'h0000_0002, 32'h0000_0000, '0},
      '{ROW_CAP,   FUNC_GET, 32'h0000_0000, 32'd17,        '0},
      '{ROW_PRED,  FUNC_PUT, 32'h0000_0002, 32'h0000_0007, '0},
      '{ROW_PRED,  FUNC_GET, 32'h7FFF_FFFF, 32'h0000_0000, '0},
      '{ROW_CAP,   FUNC_GET, 32'h0000_0000, 32'd16,        '0}
   };

   lru_key_value_cache_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hit          (rsp_hit),
      .rsp_read_value   (rsp_read_value),
      .rsp_evicted      (rsp_evicted),
      .rsp_evicted_key  (rsp_evicted_key),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int eff_capacity();
      if (cap_reg == 0) return 1;
      if (cap_reg > DEPTH_DEF) return DEPTH_DEF;
      return int'(cap_reg);
   endfunction

   function automatic void make_newest(input int s, input int lim);
      int i;
      for (i = 0; i < DEPTH_DEF; i++) begin
         if (i != s && ent_valid[i] && ent_age[i] < lim) ent_age[i]++;
      end
      ent_age[s] = 0;
   endfunction

   function automatic cache_rsp_type cache_access(input logic op, input logic [KB-1:0] k,
                                                   input logic [VB-1:0] v);
      cache_rsp_type r;
      int            s;
      int            best;
      int            i;
      r = '0;
      s = -1;
      for (i = 0; i < DEPTH_DEF; i++) begin
         if (s < 0 && ent_valid[i] && ent_key[i] == k) s = i;
      end
      if (s >= 0) begin
         r.hit = 1'b1;
         if (op == FUNC_GET) r.read_value = ent_value[s];
         else ent_value[s] = v;
         make_newest(s, ent_age[s]);
      end else if (op == FUNC_PUT) begin
         if (ent_count >= eff_capacity()) begin
            // drop the least recent entry, lowest slot on a tie
            best = 0;
            for (i = 0; i < DEPTH_DEF; i++) begin
               if (ent_valid[i] && (s < 0 || ent_age[i] > best)) begin
                  s    = i;
                  best = ent_age[i];
               end
            end
            if (s >= 0) begin
               r.evicted     = 1'b1;
               r.evicted_key = ent_key[s];
               ent_valid[s]  = 1'b0;
               ent_count--;
            end
         end
         for (i = 0; i < DEPTH_DEF; i++) begin
            if (s < 0 && !ent_valid[i]) s = i;
         end
         if (s >= 0) begin
            make_newest(s, 32'hFFFF);
            ent_valid[s] = 1'b1;
            ent_key[s]   = k;
            ent_value[s] = v;
            ent_count++;
         end
      end
      return r;
   endfunction

   // called at a rising edge, returns at the edge that accepts the transaction
   task automatic send_op(input logic op, input logic [KB-1:0] k, input logic [VB-1:0] v,
                          input bit typed, input cache_rsp_type want);
      cache_rsp_type pred;
      req_valid <= 1'b1;
      req_func  <= op;
      req_key   <= k;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      pred = cache_access(op, k, v);
      due_rsp_q.push_back(typed ? want : pred);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (due_rsp_q.size() != 0);
      @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_BITS-1:0] c);
      csr_write_enable <= 1'b1;
      csr_write_data   <= c;
      cap_reg = c;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_cnt++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      cache_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp_q.size() == 0) begin
            $error("result transaction with nothing outstanding");
            fail_cnt++;
         end else begin
            want = due_rsp_q.pop_front();
            check_field("hit", 64'(want.hit), 64'(rsp_hit));
            check_field("read_value", 64'(want.read_value), 64'(rsp_read_value));
            check_field("evicted", 64'(want.evicted), 64'(rsp_evicted));
            check_field("evicted_key", 64'(want.evicted_key), 64'(rsp_evicted_key));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : rsp_pacing
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge clock);
            if ($urandom_range(0, 3) != 0) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      logic [KB-1:0] key_pool [0:23];
      logic [KB-1:0] k;
      int            pool_n;
      int            n_items;
      int            burst_left;
      int            rand_sent;
      int            phase;
      int            i;
      int            j;
      bit            no_gaps;

      for (i = 0; i < DEPTH_DEF; i++) begin
         ent_valid[i] = 1'b0;
         ent_key[i]   = '0;
         ent_value[i] = '0;
         ent_age[i]   = 0;
      end
      ent_count = 0;
      cap_reg   = CAP_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NUM_ROWS; i++) begin
         if (dir_rows[i].kind == ROW_CAP) begin
            drain_results();
            set_capacity(dir_rows[i].value[CAP_BITS-1:0]);
         end else begin
            send_op(dir_rows[i].func, dir_rows[i].key, dir_rows[i].value,
                    dir_rows[i].kind == ROW_TYPED, dir_rows[i].want);
         end
      end

      rand_sent  = 0;
      phase      = 0;
      burst_left = $urandom_range(1, 30);
      while (rand_sent < RAND_ITEMS) begin
         drain_results();
         set_capacity(CAP_BITS'(phase < 8 ? phase_caps[phase] : $urandom_range(0, 31)));
         // a pool a bit larger than the capacity gives both hits and evictions
         pool_n = eff_capacity() + $urandom_range(1, 8);
         for (i = 0; i < pool_n; i++) key_pool[i] = $urandom();
         n_items = $urandom_range(80, 160);
         no_gaps = (phase % 4 == 3);
         for (j = 0; j < n_items; j++) begin
            if (phase == 2 && j == 20) hold_rsp = 1'b1;
            if (phase == 4 && j == 40) drain_results();
            if (!no_gaps && burst_left == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 10)) @(posedge clock);
               burst_left = $urandom_range(1, 30);
            end
            if ($urandom_range(0, 9) == 0) k = $urandom();
            else k = key_pool[$urandom_range(0, pool_n - 1)];
            send_op($urandom_range(0, 1) ? FUNC_PUT : FUNC_GET, k, $urandom(), 1'b0, '0);
            if (burst_left > 0) burst_left--;
            rand_sent++;
         end
         phase++;
      end

      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_cnt == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
